>>> src/tree_node_distance_core_macros.svh
// Assertion macros shared by the tree node distance RTL.
`ifndef TREE_NODE_DISTANCE_CORE_MACROS_SVH
`define TREE_NODE_DISTANCE_CORE_MACROS_SVH

// Same-cycle implication, checked on clk_i and disabled during reset.
`define TND_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tree node distance assertion failed");

// Next-cycle implication, checked on clk_i and disabled during reset.
`define TND_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tree node distance assertion failed");

`endif

>>> src/tnd_pkg.sv
// Shared types and constants of the tree node distance core.
package tnd_pkg;

  localparam int unsigned NODE_W     = 5;
  localparam int unsigned DIST_W     = 6;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned NODE_SPAN  = 32;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 6'd32;

  localparam logic [0:0] REG_NODE_COUNT = 1'b0;

  localparam logic OP_LINK  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK1,
    ST_WALK2,
    ST_MRD,
    ST_DONE
  } state_e;

endpackage

>>> src/tnd_in_if.sv
// Input channel carrying link and query items.
interface tnd_in_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [tnd_pkg::NODE_W-1:0] first_node;
  logic [tnd_pkg::NODE_W-1:0] second_node;

  modport source (output valid, output operation, output first_node, output second_node,
                  input ready);
  modport sink   (input valid, input operation, input first_node, input second_node,
                  output ready);
endinterface

>>> src/tnd_out_if.sv
// Output channel carrying distance results.
interface tnd_out_if;
  logic                       valid;
  logic                       ready;
  logic [tnd_pkg::DIST_W-1:0] distance;
  logic                       found;

  modport source (output valid, output distance, output found, input ready);
  modport sink   (input valid, input distance, input found, output ready);
endinterface

>>> src/tree_node_distance_core.sv
// Tree node distance core: parent table memory with lowest common ancestor walks.
// A link transfer gives no result and leaves the input ready; a query holds the input until done.
// A query result follows the parent reads of its two walks, each at most NODES + 1 reads,
// one a cycle. The next transfer can be taken in the cycle after the result is loaded;
// output stalls delay the load. Reset clears the parent valid bits and the mark bits and
// sets node_count to 32.
`include "tree_node_distance_core_macros.svh"

module tree_node_distance_core #(
  parameter int unsigned NODES = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tnd_pkg::PADDR_W-1:0]   paddr,
  input  logic [tnd_pkg::PDATA_W-1:0]   pwdata,
  output logic [tnd_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  tnd_in_if.sink                        in_i,
  tnd_out_if.source                     out_o
);

  localparam int unsigned DEPTH  = (NODES < tnd_pkg::NODE_SPAN) ? NODES : tnd_pkg::NODE_SPAN;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned STEP_W = $clog2(NODES + 1);
  localparam int unsigned CNT_W  = tnd_pkg::CNT_W;
  localparam int unsigned DIST_W = tnd_pkg::DIST_W;

  tnd_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0]  node_count_q;
  logic [CNT_W-1:0]  cnt;
  logic [IDX_W-1:0]  x_q, x_d;
  logic [IDX_W-1:0]  b_q, b_d;
  logic [STEP_W-1:0] d_q, d_d;
  logic [DIST_W-1:0] res_dist_q, res_dist_d;
  logic              res_found_q, res_found_d;
  logic [DEPTH-1:0]  has_par_q;
  logic [DEPTH-1:0]  marked_q;

  logic [IDX_W-1:0]  parent_mem [DEPTH];
  logic [IDX_W-1:0]  par_rdata_q;
  logic [DIST_W-1:0] mark_mem [DEPTH];
  logic [DIST_W-1:0] mark_rdata_q;

  logic              out_valid_q;
  logic [DIST_W-1:0] out_dist_q;
  logic              out_found_q;

  logic              in_acc;
  logic              a_ok;
  logic              b_ok;
  logic              link_we;
  logic              up_ok;
  logic              step_max;
  logic              out_free;
  logic              cfg_we;
  logic [IDX_W-1:0]  rd_addr;
  logic              mark_we;
  logic              mark_clr;
  logic              load_out;
  logic              in_walk;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == tnd_pkg::REG_NODE_COUNT);
  assign prdata = (paddr[2] == tnd_pkg::REG_NODE_COUNT) ?
                  tnd_pkg::PDATA_W'(node_count_q) : '0;

  assign cnt = (node_count_q < CNT_W'(DEPTH)) ? node_count_q : CNT_W'(DEPTH);

  assign in_i.ready = (state_q == tnd_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign a_ok       = (CNT_W'(in_i.first_node) < cnt);
  assign b_ok       = (CNT_W'(in_i.second_node) < cnt);
  assign link_we    = in_acc && (in_i.operation == tnd_pkg::OP_LINK) && a_ok && b_ok;

  assign up_ok    = has_par_q[x_q] && (CNT_W'(par_rdata_q) < cnt);
  assign step_max = (d_q >= STEP_W'(NODES));
  assign out_free = !out_valid_q || out_o.ready;
  assign in_walk  = (state_q == tnd_pkg::ST_WALK1) || (state_q == tnd_pkg::ST_WALK2);

  assign out_o.valid    = out_valid_q;
  assign out_o.distance = out_dist_q;
  assign out_o.found    = out_found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tnd_pkg::ST_IDLE;
      node_count_q <= tnd_pkg::NODE_COUNT_RST;
      has_par_q    <= '0;
      marked_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        node_count_q <= pwdata[CNT_W-1:0];
      end
      if (link_we) begin
        has_par_q[IDX_W'(in_i.second_node)] <= 1'b1;
      end
      if (mark_clr) begin
        marked_q <= '0;
      end else if (mark_we) begin
        marked_q[x_q] <= 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q         <= x_d;
    b_q         <= b_d;
    d_q         <= d_d;
    res_dist_q  <= res_dist_d;
    res_found_q <= res_found_d;
    if (load_out) begin
      out_dist_q  <= res_dist_q;
      out_found_q <= res_found_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      parent_mem[IDX_W'(in_i.second_node)] <= IDX_W'(in_i.first_node);
    end
    par_rdata_q <= parent_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[x_q] <= DIST_W'(d_q);
    end
    mark_rdata_q <= mark_mem[x_q];
  end

  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    b_d         = b_q;
    d_d         = d_q;
    res_dist_d  = res_dist_q;
    res_found_d = res_found_q;
    rd_addr     = x_q;
    mark_we     = 1'b0;
    mark_clr    = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      tnd_pkg::ST_IDLE: begin
        rd_addr = IDX_W'(in_i.first_node);
        if (in_acc && (in_i.operation == tnd_pkg::OP_QUERY)) begin
          res_dist_d  = '0;
          res_found_d = 1'b0;
          if (a_ok && b_ok) begin
            x_d      = IDX_W'(in_i.first_node);
            b_d      = IDX_W'(in_i.second_node);
            d_d      = '0;
            mark_clr = 1'b1;
            state_d  = tnd_pkg::ST_WALK1;
          end else begin
            state_d = tnd_pkg::ST_DONE;
          end
        end
      end
      tnd_pkg::ST_WALK1: begin
        mark_we = !marked_q[x_q];
        if (!up_ok) begin
          x_d     = b_q;
          d_d     = '0;
          rd_addr = b_q;
          state_d = tnd_pkg::ST_WALK2;
        end else if (step_max) begin
          state_d = tnd_pkg::ST_DONE;
        end else begin
          x_d     = par_rdata_q;
          rd_addr = par_rdata_q;
          d_d     = d_q + 1'b1;
        end
      end
      tnd_pkg::ST_WALK2: begin
        if (marked_q[x_q]) begin
          state_d = tnd_pkg::ST_MRD;
        end else if (!up_ok || step_max) begin
          state_d = tnd_pkg::ST_DONE;
        end else begin
          x_d     = par_rdata_q;
          rd_addr = par_rdata_q;
          d_d     = d_q + 1'b1;
        end
      end
      tnd_pkg::ST_MRD: begin
        res_dist_d  = DIST_W'(d_q) + mark_rdata_q;
        res_found_d = 1'b1;
        state_d     = tnd_pkg::ST_DONE;
      end
      tnd_pkg::ST_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = tnd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tnd_pkg::ST_IDLE;
      end
    endcase
  end

  `TND_ASSERT(a_mark_read_hits, state_q == tnd_pkg::ST_MRD, marked_q[x_q])
  `TND_ASSERT(a_step_bound, in_walk, d_q <= STEP_W'(NODES))
  `TND_ASSERT(a_result_from_done, $rose(out_valid_q), $past(state_q) == tnd_pkg::ST_DONE)
  `TND_ASSERT_NEXT(a_marks_cleared, mark_clr, marked_q == '0)

endmodule
